// ----- design/snfcs_pkg.sv -----
// ----------------------------------------------------------------------------
// snfcs_pkg: shared definitions for the spi nor flash command sequencer
// Field widths, request and result codes, flash opcodes, the sequencer
// phase type and the result word layout.
// ----------------------------------------------------------------------------
package snfcs_pkg;

   // default geometry
   localparam int PAGE_BYTES_DEF   = 256;
   localparam int ADDRESS_BITS_DEF = 24;

   // port field widths
   localparam int FUNC_W  = 2;
   localparam int OP_W    = 4;
   localparam int ADDR_W  = 24;
   localparam int LEN_W   = 25;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 24;
   localparam int FPOS_W  = 3;

   // result queue geometry: an item gives at most two results
   localparam int MAX_RES = 2;
   localparam int Q_DEPTH = 4;
   localparam int Q_IDX_W = 2;
   localparam int Q_CNT_W = 3;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WDATA = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd2;

   // operations
   localparam logic [OP_W-1:0] OP_ID           = 4'd0;
   localparam logic [OP_W-1:0] OP_STATUS       = 4'd1;
   localparam logic [OP_W-1:0] OP_SECTOR_ERASE = 4'd2;
   localparam logic [OP_W-1:0] OP_ERASE_32K    = 4'd3;
   localparam logic [OP_W-1:0] OP_ERASE_64K    = 4'd4;
   localparam logic [OP_W-1:0] OP_CHIP_ERASE   = 4'd5;
   localparam logic [OP_W-1:0] OP_WRITE        = 4'd6;
   localparam logic [OP_W-1:0] OP_READ         = 4'd7;
   localparam logic [OP_W-1:0] OP_WRITE_ENABLE = 4'd8;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SPI   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VALUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEED  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

   // flash opcodes and filler bytes
   localparam logic [BYTE_W-1:0] CMD_READ_ID   = 8'h9F;
   localparam logic [BYTE_W-1:0] CMD_STATUS    = 8'h05;
   localparam logic [BYTE_W-1:0] CMD_SECTOR    = 8'h20;
   localparam logic [BYTE_W-1:0] CMD_BLOCK_32K = 8'h52;
   localparam logic [BYTE_W-1:0] CMD_BLOCK_64K = 8'hD8;
   localparam logic [BYTE_W-1:0] CMD_CHIP      = 8'hC7;
   localparam logic [BYTE_W-1:0] CMD_PROGRAM   = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_FAST_READ = 8'h0B;
   localparam logic [BYTE_W-1:0] CMD_WREN      = 8'h06;
   localparam logic [BYTE_W-1:0] DUMMY_BYTE    = 8'hFF;

   // sequencer phases
   typedef enum logic [10:0] {
      PH_IDLE      = 11'b000_0000_0001,
      PH_ID        = 11'b000_0000_0010,
      PH_STAT      = 11'b000_0000_0100,
      PH_WREN_ONLY = 11'b000_0000_1000,
      PH_PRE_WREN  = 11'b000_0001_0000,
      PH_PRE_POLL  = 11'b000_0010_0000,
      PH_HDR       = 11'b000_0100_0000,
      PH_WR_NEED   = 11'b000_1000_0000,
      PH_WR_DATA   = 11'b001_0000_0000,
      PH_RD_DATA   = 11'b010_0000_0000,
      PH_POST_POLL = 11'b100_0000_0000
   } phase_type;

   // one result word
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  spi_byte;
      logic               frame_start;
      logic               frame_end;
      logic [VALUE_W-1:0] host_value;
      logic               last;
   } res_type;

   // opcode for each operation
   function automatic logic [BYTE_W-1:0] op_code(input logic [OP_W-1:0] op);
      logic [BYTE_W-1:0] c;
      unique case (op)
         OP_ID:           c = CMD_READ_ID;
         OP_STATUS:       c = CMD_STATUS;
         OP_SECTOR_ERASE: c = CMD_SECTOR;
         OP_ERASE_32K:    c = CMD_BLOCK_32K;
         OP_ERASE_64K:    c = CMD_BLOCK_64K;
         OP_CHIP_ERASE:   c = CMD_CHIP;
         OP_WRITE:        c = CMD_PROGRAM;
         OP_READ:         c = CMD_FAST_READ;
         OP_WRITE_ENABLE: c = CMD_WREN;
         default:         c = '0;
      endcase
      return c;
   endfunction

   // spi byte result
   function automatic res_type mk_send(input logic [BYTE_W-1:0] b, input logic fs,
                                       input logic fe);
      res_type r;
      r             = '0;
      r.kind        = KIND_SPI;
      r.spi_byte    = b;
      r.frame_start = fs;
      r.frame_end   = fe;
      return r;
   endfunction

   // value to host
   function automatic res_type mk_value(input logic [VALUE_W-1:0] v);
      res_type r;
      r            = '0;
      r.kind       = KIND_VALUE;
      r.host_value = v;
      return r;
   endfunction

   // result that carries only a kind
   function automatic res_type mk_kind(input logic [KIND_W-1:0] k);
      res_type r;
      r      = '0;
      r.kind = k;
      return r;
   endfunction

endpackage

// ----- design/spi_nor_flash_command_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_unit: spi nor flash command sequencer
// Turns host requests into a framed spi byte stream, polls busy around
// erase and program, splits writes at page boundaries.
// ----------------------------------------------------------------------------
// Each accepted word is latched in an input register and handled, once the
// result queue has room, by one pass of the sequencer logic, which writes
// its one or two results into a four-word result queue. A new word is taken
// every cycle as long as the queue has room for two more results, so words
// that give one result run at one per cycle; words that give two (a read
// data byte, the end of an id or status read) are held back by the result
// drain rate of one word per cycle while rsp_stall is low. A word passes the
// input register and then the result queue. PAGE_BYTES must be a power of two.
module spi_nor_flash_command_sequencer_unit
   import snfcs_pkg::*;
#(
   parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [ADDR_W-1:0]  req_address,
   input  logic [LEN_W-1:0]   req_length,
   input  logic [BYTE_W-1:0]  req_write_byte,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [BYTE_W-1:0]  rsp_spi_byte,
   output logic               rsp_frame_start,
   output logic               rsp_frame_end,
   output logic [VALUE_W-1:0] rsp_host_value,
   output logic               rsp_last
);

   localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
   localparam int HDR_W      = ADDR_BYTES * 8;
   localparam int PAGE_W     = $clog2(PAGE_BYTES);
   localparam int CHUNK_W    = PAGE_W + 1;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [FUNC_W-1:0]  func_ff;
   logic [OP_W-1:0]    op_in_ff;
   logic [ADDR_W-1:0]  addr_in_ff;
   logic [LEN_W-1:0]   len_in_ff;
   logic [BYTE_W-1:0]  wbyte_ff;
   logic [BYTE_W-1:0]  rx_ff;

   // sequencer state
   phase_type             phase_ff, phase_in;
   logic [OP_W-1:0]       cur_op_ff, cur_op_in;
   logic [ADDRESS_BITS-1:0] cur_addr_ff, cur_addr_in;
   logic [LEN_W-1:0]      bytes_ff, bytes_in;
   logic [CHUNK_W-1:0]    chunk_ff, chunk_in;
   logic [FPOS_W-1:0]     fpos_ff, fpos_in;
   logic [VALUE_W-1:0]    id_acc_ff, id_acc_in;

   // result queue
   res_type             q_ff [Q_DEPTH];
   res_type             q_in [Q_DEPTH];
   logic [Q_IDX_W-1:0]  head_ff, head_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;
   logic [Q_IDX_W-1:0]  tail;

   // working signals
   logic                     accept;
   logic                     pop;
   logic                     fire;
   res_type                  res0, res1;
   logic [1:0]               n_res;
   logic [ADDRESS_BITS+ADDR_W-1:0] addr_ext;
   logic [ADDRESS_BITS-1:0]  start_addr;
   logic [HDR_W+ADDRESS_BITS-1:0] hdr_ext;
   logic [HDR_W-1:0]         hdr_word;
   logic [FPOS_W-1:0]        hdr_k;
   logic [BYTE_W-1:0]        hdr_byte;
   logic [FPOS_W-1:0]        hdr_last;
   logic [VALUE_W-1:0]       id_next;
   logic [LEN_W-1:0]         bytes_dec;
   logic [CHUNK_W-1:0]       chunk_dec;

   // bytes left in the chunk that starts at a given address
   function automatic logic [CHUNK_W-1:0] first_chunk(input logic [ADDRESS_BITS-1:0] a,
                                                      input logic [LEN_W-1:0] n);
      logic [CHUNK_W-1:0] room_left;
      room_left = CHUNK_W'(PAGE_BYTES) - {1'b0, a[PAGE_W-1:0]};
      return (n < LEN_W'(room_left)) ? n[CHUNK_W-1:0] : room_left;
   endfunction

   // handshakes
   assign pop       = (count_ff != '0) && !rsp_stall;
   assign fire      = in_valid_ff &&
                      ((count_ff <= Q_CNT_W'(Q_DEPTH - MAX_RES)) ||
                       ((count_ff == Q_CNT_W'(Q_DEPTH - MAX_RES + 1)) && pop));
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // address helpers
   assign addr_ext   = {{ADDRESS_BITS{1'b0}}, addr_in_ff};
   assign start_addr = addr_ext[ADDRESS_BITS-1:0];
   assign hdr_ext    = {{HDR_W{1'b0}}, cur_addr_ff};
   assign hdr_word   = hdr_ext[HDR_W-1:0];
   assign hdr_k      = fpos_ff + FPOS_W'(1);
   assign id_next    = {id_acc_ff[VALUE_W-BYTE_W-1:0], rx_ff};
   assign bytes_dec  = bytes_ff - LEN_W'(1);
   assign chunk_dec  = chunk_ff - CHUNK_W'(1);

   // address byte k of the header, most significant first
   always_comb begin
      hdr_byte = '0;
      for (int b = 0; b < ADDR_BYTES; b++) begin
         if (hdr_k == FPOS_W'(ADDR_BYTES - b)) begin
            hdr_byte = hdr_word[8*b +: 8];
         end
      end
   end

   // position of the last header byte
   always_comb begin
      if (cur_op_ff == OP_CHIP_ERASE) begin
         hdr_last = '0;
      end else if (cur_op_ff == OP_READ) begin
         hdr_last = FPOS_W'(ADDR_BYTES + 1);
      end else begin
         hdr_last = FPOS_W'(ADDR_BYTES);
      end
   end

   // sequencer step
   always_comb begin
      phase_in    = phase_ff;
      cur_op_in   = cur_op_ff;
      cur_addr_in = cur_addr_ff;
      bytes_in    = bytes_ff;
      chunk_in    = chunk_ff;
      fpos_in     = fpos_ff;
      id_acc_in   = id_acc_ff;
      res0        = '0;
      res1        = '0;
      n_res       = 2'd0;

      if (fire) begin
         if ((func_ff == FUNC_START) && (phase_ff == PH_IDLE)) begin
            // new request
            cur_op_in   = op_in_ff;
            cur_addr_in = start_addr;
            bytes_in    = len_in_ff;
            chunk_in    = '0;
            fpos_in     = '0;
            id_acc_in   = '0;
            n_res       = 2'd1;
            unique case (op_in_ff) inside
               OP_ID: begin
                  phase_in = PH_ID;
                  res0     = mk_send(CMD_READ_ID, 1'b1, 1'b0);
               end
               OP_STATUS: begin
                  phase_in = PH_STAT;
                  res0     = mk_send(CMD_STATUS, 1'b1, 1'b0);
               end
               OP_WRITE_ENABLE: begin
                  phase_in = PH_WREN_ONLY;
                  res0     = mk_send(CMD_WREN, 1'b1, 1'b1);
               end
               OP_SECTOR_ERASE, OP_ERASE_32K, OP_ERASE_64K, OP_CHIP_ERASE: begin
                  phase_in = PH_PRE_WREN;
                  res0     = mk_send(CMD_WREN, 1'b1, 1'b1);
               end
               OP_WRITE: begin
                  chunk_in = first_chunk(start_addr, len_in_ff);
                  phase_in = PH_PRE_WREN;
                  res0     = mk_send(CMD_WREN, 1'b1, 1'b1);
               end
               OP_READ: begin
                  phase_in = PH_HDR;
                  res0     = mk_send(CMD_FAST_READ, 1'b1, 1'b0);
               end
               default: begin
                  phase_in = PH_IDLE;
                  res0     = mk_kind(KIND_DONE);
               end
            endcase
         end else if ((func_ff == FUNC_WDATA) && (phase_ff == PH_WR_NEED)) begin
            // program data byte from the host
            phase_in = PH_WR_DATA;
            n_res    = 2'd1;
            res0     = mk_send(wbyte_ff, 1'b0, chunk_ff == CHUNK_W'(1));
         end else if (func_ff == FUNC_RX) begin
            unique case (phase_ff)
               PH_ID: begin
                  if (fpos_ff != '0) begin
                     id_acc_in = id_next;
                  end
                  if (fpos_ff < FPOS_W'(3)) begin
                     fpos_in = hdr_k;
                     n_res   = 2'd1;
                     res0    = mk_send(DUMMY_BYTE, 1'b0, hdr_k == FPOS_W'(3));
                  end else begin
                     phase_in = PH_IDLE;
                     n_res    = 2'd2;
                     res0     = mk_value(id_next);
                     res1     = mk_kind(KIND_DONE);
                  end
               end
               PH_STAT: begin
                  if (fpos_ff == '0) begin
                     fpos_in = FPOS_W'(1);
                     n_res   = 2'd1;
                     res0    = mk_send(DUMMY_BYTE, 1'b0, 1'b1);
                  end else begin
                     phase_in = PH_IDLE;
                     n_res    = 2'd2;
                     res0     = mk_value({{(VALUE_W-BYTE_W){1'b0}}, rx_ff});
                     res1     = mk_kind(KIND_DONE);
                  end
               end
               PH_WREN_ONLY: begin
                  phase_in = PH_IDLE;
                  n_res    = 2'd1;
                  res0     = mk_kind(KIND_DONE);
               end
               PH_PRE_WREN: begin
                  phase_in = PH_PRE_POLL;
                  fpos_in  = '0;
                  n_res    = 2'd1;
                  res0     = mk_send(CMD_STATUS, 1'b1, 1'b0);
               end
               PH_PRE_POLL, PH_POST_POLL: begin
                  n_res = 2'd1;
                  if (fpos_ff == '0) begin
                     // status byte clock-out
                     fpos_in = FPOS_W'(1);
                     res0    = mk_send(DUMMY_BYTE, 1'b0, 1'b1);
                  end else if (rx_ff[0]) begin
                     // still busy: poll again
                     fpos_in = '0;
                     res0    = mk_send(CMD_STATUS, 1'b1, 1'b0);
                  end else if (phase_ff == PH_PRE_POLL) begin
                     phase_in = PH_HDR;
                     fpos_in  = '0;
                     res0     = mk_send(op_code(cur_op_ff), 1'b1,
                                        cur_op_ff == OP_CHIP_ERASE);
                  end else if ((cur_op_ff == OP_WRITE) && (bytes_ff != '0)) begin
                     // next page chunk
                     chunk_in = first_chunk(cur_addr_ff, bytes_ff);
                     phase_in = PH_PRE_WREN;
                     res0     = mk_send(CMD_WREN, 1'b1, 1'b1);
                  end else begin
                     phase_in = PH_IDLE;
                     res0     = mk_kind(KIND_DONE);
                  end
               end
               PH_HDR: begin
                  n_res = 2'd1;
                  if (fpos_ff < hdr_last) begin
                     fpos_in = hdr_k;
                     if (hdr_k <= FPOS_W'(ADDR_BYTES)) begin
                        res0 = mk_send(hdr_byte, 1'b0,
                                       (hdr_k == FPOS_W'(ADDR_BYTES)) &&
                                       (cur_op_ff != OP_READ) &&
                                       ((cur_op_ff != OP_WRITE) || (chunk_ff == '0)));
                     end else begin
                        res0 = mk_send(DUMMY_BYTE, 1'b0, bytes_ff == '0);
                     end
                  end else if (cur_op_ff == OP_READ) begin
                     if (bytes_ff != '0) begin
                        phase_in = PH_RD_DATA;
                        res0     = mk_send(DUMMY_BYTE, 1'b0, bytes_ff == LEN_W'(1));
                     end else begin
                        phase_in = PH_IDLE;
                        res0     = mk_kind(KIND_DONE);
                     end
                  end else if ((cur_op_ff == OP_WRITE) && (chunk_ff != '0)) begin
                     phase_in = PH_WR_NEED;
                     res0     = mk_kind(KIND_NEED);
                  end else begin
                     phase_in = PH_POST_POLL;
                     fpos_in  = '0;
                     res0     = mk_send(CMD_STATUS, 1'b1, 1'b0);
                  end
               end
               PH_WR_DATA: begin
                  chunk_in    = chunk_dec;
                  bytes_in    = bytes_dec;
                  cur_addr_in = cur_addr_ff + ADDRESS_BITS'(1);
                  n_res       = 2'd1;
                  if (chunk_dec != '0) begin
                     phase_in = PH_WR_NEED;
                     res0     = mk_kind(KIND_NEED);
                  end else begin
                     phase_in = PH_POST_POLL;
                     fpos_in  = '0;
                     res0     = mk_send(CMD_STATUS, 1'b1, 1'b0);
                  end
               end
               PH_RD_DATA: begin
                  bytes_in    = bytes_dec;
                  cur_addr_in = cur_addr_ff + ADDRESS_BITS'(1);
                  n_res       = 2'd2;
                  res0        = mk_value({{(VALUE_W-BYTE_W){1'b0}}, rx_ff});
                  if (bytes_dec != '0) begin
                     res1 = mk_send(DUMMY_BYTE, 1'b0, bytes_dec == LEN_W'(1));
                  end else begin
                     phase_in = PH_IDLE;
                     res1     = mk_kind(KIND_DONE);
                  end
               end
               PH_IDLE, PH_WR_NEED: begin
                  n_res = 2'd0;
               end
               default: begin
                  n_res = 2'd0;
               end
            endcase
         end

         // flag the final result of this word
         if (n_res == 2'd1) begin
            res0.last = 1'b1;
         end else if (n_res == 2'd2) begin
            res1.last = 1'b1;
         end
      end
   end

   // result queue update
   assign tail = head_ff + count_ff[Q_IDX_W-1:0];

   always_comb begin
      q_in = q_ff;
      if (n_res != 2'd0) begin
         q_in[tail] = res0;
      end
      if (n_res == 2'd2) begin
         q_in[tail + Q_IDX_W'(1)] = res1;
      end
      head_in  = head_ff + Q_IDX_W'(pop);
      count_in = count_ff + Q_CNT_W'(n_res) - Q_CNT_W'(pop);
   end

   // result port
   assign rsp_valid       = count_ff != '0;
   assign rsp_kind        = q_ff[head_ff].kind;
   assign rsp_spi_byte    = q_ff[head_ff].spi_byte;
   assign rsp_frame_start = q_ff[head_ff].frame_start;
   assign rsp_frame_end   = q_ff[head_ff].frame_end;
   assign rsp_host_value  = q_ff[head_ff].host_value;
   assign rsp_last        = q_ff[head_ff].last;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         cur_op_ff   <= '0;
         cur_addr_ff <= '0;
         bytes_ff    <= '0;
         chunk_ff    <= '0;
         fpos_ff     <= '0;
         id_acc_ff   <= '0;
         head_ff     <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         cur_op_ff   <= cur_op_in;
         cur_addr_ff <= cur_addr_in;
         bytes_ff    <= bytes_in;
         chunk_ff    <= chunk_in;
         fpos_ff     <= fpos_in;
         id_acc_ff   <= id_acc_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         op_in_ff   <= req_operation;
         addr_in_ff <= req_address;
         len_in_ff  <= req_length;
         wbyte_ff   <= req_write_byte;
         rx_ff      <= req_rx_byte;
      end
      q_ff <= q_in;
   end

`ifndef SYNTHESIS
   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue overflow");

   // a chunk never exceeds the bytes still to write
   a_chunk_bound: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_WR_NEED) || (phase_ff == PH_WR_DATA)) |->
      (LEN_W'(chunk_ff) <= bytes_ff))
      else $error("write chunk larger than remaining length");

   // frame position stays within the longest header
   a_fpos_bound: assert property (@(posedge clock) disable iff (reset)
      fpos_ff <= FPOS_W'(ADDR_BYTES + 1))
      else $error("frame position out of range");

   // done always closes the results of a word
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_DONE)) |-> rsp_last)
      else $error("done result without last flag");

   // framing only on spi bytes
   a_frame_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_SPI)) |-> (!rsp_frame_start && !rsp_frame_end))
      else $error("frame flags on a non-spi result");
`endif

endmodule
